>>> hw/rtl/tssr_pkg.sv
// package: shared types, constants and register codes for the scanline renderer
package tssr_pkg;

  localparam int LINE_WIDTH_DEF   = 160;
  localparam int MAX_SPRITES_DEF  = 10;
  localparam int SPRITE_COUNT_DEF = 40;

  localparam int TILE_BYTES = 8192;
  localparam int MAX_GROUPS = 20;
  localparam logic [7:0] WIN_HIDE = 8'd166;

  localparam logic [1:0] OP_TILE   = 2'd0;
  localparam logic [1:0] OP_ATTR   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [3:0] REG_LCD_CONTROL = 4'd0;
  localparam logic [3:0] REG_SCROLL_Y    = 4'd1;
  localparam logic [3:0] REG_SCROLL_X    = 4'd2;
  localparam logic [3:0] REG_WINDOW_Y    = 4'd3;
  localparam logic [3:0] REG_WINDOW_X    = 4'd4;
  localparam logic [3:0] REG_BG_PALETTE  = 4'd5;
  localparam logic [3:0] REG_SPR_PAL_0   = 4'd6;
  localparam logic [3:0] REG_SPR_PAL_1   = 4'd7;

  localparam logic [7:0] LCD_CONTROL_RST = 8'h91;
  localparam logic [7:0] BG_PALETTE_RST  = 8'hfc;

  typedef struct packed {
    logic [1:0]  operation;
    logic [12:0] address;
    logic [7:0]  data;
    logic [7:0]  line_number;
    logic        skip_line;
  } in_t;

  typedef struct packed {
    logic [4:0]  pixel_group;
    logic [15:0] shades;
    logic        last;
  } out_t;

endpackage

>>> hw/rtl/tile_sprite_scanline_renderer_unit.sv
// top level: tile map, window and sprite scanline renderer with its memories and sequencer
//
// Commands are taken when start is high and busy is low. Tile and attribute writes leave
// busy low. A render (skip_line clear) raises busy and walks the line with one shared
// tile-memory read port: per background/window pixel a map byte, low plane, high plane and
// write step; if sprites are enabled, each attribute slot is scanned in turn until the
// sprite limit is met or every slot is scanned, then per taken sprite a fetch of its four
// attribute bytes and two planes and, per pixel, an index read and a merge. The line then
// goes out as one word per group of eight pixels, each group reading its eight shades and
// then strobing. result is valid only while done is high, for one cycle, and the receiver
// must take it then. Configuration writes are always ready and must only be issued while
// busy is low.
module tile_sprite_scanline_renderer_unit #(
  parameter int LINE_WIDTH   = tssr_pkg::LINE_WIDTH_DEF,
  parameter int MAX_SPRITES  = tssr_pkg::MAX_SPRITES_DEF,
  parameter int SPRITE_COUNT = tssr_pkg::SPRITE_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tssr_pkg::in_t cmd,
  output logic          done,
  output tssr_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  localparam int PXW = $clog2(LINE_WIDTH + 1);
  localparam int PIW = $clog2(LINE_WIDTH);
  localparam int SIW = $clog2(SPRITE_COUNT + 1);
  localparam int SNW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int OAW = SNW + 2;
  localparam int OAM_BYTES = 4 * SPRITE_COUNT;
  localparam int TKW = $clog2(MAX_SPRITES + 1);
  localparam int TIW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
  localparam int GROUPS_RAW = (LINE_WIDTH + 7) / 8;
  localparam int GROUPS = (GROUPS_RAW > tssr_pkg::MAX_GROUPS) ? tssr_pkg::MAX_GROUPS
                                                              : GROUPS_RAW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_BG_MAP = 5'd1;
  localparam logic [4:0] S_BG_NUM = 5'd2;
  localparam logic [4:0] S_BG_LO  = 5'd3;
  localparam logic [4:0] S_BG_HI  = 5'd4;
  localparam logic [4:0] S_SC_Y   = 5'd5;
  localparam logic [4:0] S_SC_X   = 5'd6;
  localparam logic [4:0] S_SC_CHK = 5'd7;
  localparam logic [4:0] S_SP_Y   = 5'd8;
  localparam logic [4:0] S_SP_X   = 5'd9;
  localparam logic [4:0] S_SP_T   = 5'd10;
  localparam logic [4:0] S_SP_A   = 5'd11;
  localparam logic [4:0] S_SP_ADR = 5'd12;
  localparam logic [4:0] S_SP_LO  = 5'd13;
  localparam logic [4:0] S_SP_HI  = 5'd14;
  localparam logic [4:0] S_SP_PRD = 5'd15;
  localparam logic [4:0] S_SP_PWR = 5'd16;
  localparam logic [4:0] S_OUT_RD = 5'd17;
  localparam logic [4:0] S_OUT_CAP = 5'd18;
  localparam logic [4:0] S_OUT_EMIT = 5'd19;

  logic [7:0] lcd_control, scroll_y, scroll_x, window_y, window_x;
  logic [7:0] bg_palette, sprite_palette_0, sprite_palette_1;

  logic [4:0] state;
  logic [7:0] line;
  logic [PXW-1:0] px;
  logic [SIW-1:0] spr_i;
  logic [TKW-1:0] taken;
  logic [SNW-1:0] sel [MAX_SPRITES];
  logic [7:0] spr_y, spr_x, spr_tile, spr_attr;
  logic [12:0] row_addr;
  logic [7:0] lo_byte, hi_byte;
  logic [2:0] nx;
  logic [4:0] grp;
  logic [2:0] k;
  logic [15:0] pack;

  // memories
  localparam int TILE_BYTES_L = tssr_pkg::TILE_BYTES;
  logic [7:0] tile_mem [TILE_BYTES_L];
  logic [7:0] oam_mem [OAM_BYTES];
  logic [1:0] color_mem [LINE_WIDTH];
  logic [1:0] shade_mem [LINE_WIDTH];
  logic [12:0] t_raddr;
  logic [7:0]  t_q;
  logic [OAW-1:0] o_raddr;
  logic [7:0]  o_q;
  logic [PIW-1:0] c_raddr, s_raddr, s_waddr;
  logic [1:0]  c_q, s_q, s_wdata;
  logic        s_we, c_we;

  logic accept, cfg_write;
  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // background and window address
  logic       win_on, src_on, map_sel;
  logic [7:0] mx, my, mx_bg, my_bg, mx_win, my_win;
  logic [12:0] map_addr, bg_row_addr;
  logic [7:0] tnum;
  logic [2:0] bg_bit;
  logic [1:0] bg_c;

  always_comb begin
    mx_bg  = scroll_x + 8'(px);
    my_bg  = line + scroll_y;
    mx_win = 8'(9'(px) + 9'd7 - {1'b0, window_x});
    my_win = line - window_y;
    win_on = lcd_control[5] && (window_x < tssr_pkg::WIN_HIDE) && (line >= window_y)
             && ((9'(px) + 9'd7) >= {1'b0, window_x});
    src_on = win_on || lcd_control[0];
    mx      = win_on ? mx_win : mx_bg;
    my      = win_on ? my_win : my_bg;
    map_sel = win_on ? lcd_control[6] : lcd_control[3];
    map_addr = {2'b11, map_sel, my[7:3], mx[7:3]};
    tnum = t_q;
    if (lcd_control[4]) begin
      bg_row_addr = {1'b0, tnum, 4'b0000};
    end else begin
      // signed tile numbers around the middle of tile memory
      bg_row_addr = 13'h1000 + {tnum[7], tnum, 4'b0000};
    end
    bg_row_addr = bg_row_addr + {9'b0, my[2:0], 1'b0};
    bg_bit = 3'd7 - mx[2:0];
    bg_c   = src_on ? {t_q[bg_bit], lo_byte[bg_bit]} : 2'b00;
  end

  // sprite geometry
  logic       h16;
  logic [9:0] dd;
  logic       spr_hit;
  logic [3:0] yoff, srow;
  logic [7:0] tile_eff;
  logic [12:0] spr_row_addr;
  logic [2:0] sbit;
  logic [1:0] spr_c;
  logic [9:0] psum;
  logic       spr_on;
  logic [7:0] spal;
  logic [TKW-1:0] taken_inc;
  logic [TIW-1:0] tk_m1;
  logic [SNW-1:0] cur_n;

  always_comb begin
    h16 = lcd_control[2];
    dd  = 10'(line) + 10'd16 - 10'((state == S_SC_CHK) ? spr_y : spr_y);
    spr_hit = !dd[9] && (dd[8:0] < (h16 ? 9'd16 : 9'd8))
              && (10'(o_q) < 10'(LINE_WIDTH + 8));
    taken_inc = taken + TKW'(spr_hit);
    tk_m1 = TIW'(taken - TKW'(1));
    cur_n = sel[tk_m1];
    yoff = dd[3:0];
    srow = o_q[6] ? ((h16 ? 4'd15 : 4'd7) - yoff) : yoff;
    tile_eff = h16 ? {spr_tile[7:1], 1'b0} : spr_tile;
    spr_row_addr = {1'b0, tile_eff, 4'b0000} + {8'b0, srow, 1'b0};
    sbit  = spr_attr[5] ? nx : (3'd7 - nx);
    spr_c = {hi_byte[sbit], lo_byte[sbit]};
    psum  = 10'(spr_x) + 10'(nx);
    spr_on = (psum >= 10'd8) && ((psum - 10'd8) < 10'(LINE_WIDTH)) && (spr_c != 2'b00);
    spal  = spr_attr[4] ? sprite_palette_1 : sprite_palette_0;
  end

  // memory port selection
  logic [7:0] pos;
  always_comb begin
    t_raddr = map_addr;
    case (state)
      S_BG_NUM: t_raddr = bg_row_addr;
      S_BG_LO:  t_raddr = row_addr + 13'd1;
      S_SP_ADR: t_raddr = spr_row_addr;
      S_SP_LO:  t_raddr = row_addr + 13'd1;
      default:  t_raddr = map_addr;
    endcase
    o_raddr = OAW'({spr_i[SNW-1:0], 2'd0});
    case (state)
      S_SC_X:  o_raddr = OAW'({spr_i[SNW-1:0], 2'd1});
      S_SP_Y:  o_raddr = OAW'({cur_n, 2'd0});
      S_SP_X:  o_raddr = OAW'({cur_n, 2'd1});
      S_SP_T:  o_raddr = OAW'({cur_n, 2'd2});
      S_SP_A:  o_raddr = OAW'({cur_n, 2'd3});
      default: o_raddr = OAW'({spr_i[SNW-1:0], 2'd0});
    endcase
    pos     = {grp, k};
    c_raddr = PIW'(psum - 10'd8);
    s_raddr = PIW'(pos);
    c_we    = (state == S_BG_HI);
    s_we    = 1'b0;
    s_waddr = PIW'(px);
    // nothing drawn at all leaves shade zero
    s_wdata = src_on ? 2'(bg_palette >> {bg_c, 1'b0}) : 2'b00;
    if (state == S_BG_HI) begin
      s_we = 1'b1;
    end else if (state == S_SP_PWR) begin
      // behind-background sprites show only over index zero
      s_we    = spr_on && (!spr_attr[7] || (c_q == 2'b00));
      s_waddr = PIW'(psum - 10'd8);
      s_wdata = 2'(spal >> {spr_c, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd.operation == tssr_pkg::OP_TILE)) begin
      tile_mem[cmd.address] <= cmd.data;
    end
    t_q <= tile_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd.operation == tssr_pkg::OP_ATTR) && (32'(cmd.address) < OAM_BYTES)) begin
      oam_mem[OAW'(cmd.address)] <= cmd.data;
    end
    o_q <= oam_mem[o_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      color_mem[PIW'(px)] <= bg_c;
    end
    c_q <= color_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      shade_mem[s_waddr] <= s_wdata;
    end
    s_q <= shade_mem[s_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control      <= tssr_pkg::LCD_CONTROL_RST;
      scroll_y         <= 8'd0;
      scroll_x         <= 8'd0;
      window_y         <= 8'd0;
      window_x         <= 8'd0;
      bg_palette       <= tssr_pkg::BG_PALETTE_RST;
      sprite_palette_0 <= 8'd0;
      sprite_palette_1 <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        tssr_pkg::REG_LCD_CONTROL: lcd_control      <= cfg_data;
        tssr_pkg::REG_SCROLL_Y:    scroll_y         <= cfg_data;
        tssr_pkg::REG_SCROLL_X:    scroll_x         <= cfg_data;
        tssr_pkg::REG_WINDOW_Y:    window_y         <= cfg_data;
        tssr_pkg::REG_WINDOW_X:    window_x         <= cfg_data;
        tssr_pkg::REG_BG_PALETTE:  bg_palette       <= cfg_data;
        tssr_pkg::REG_SPR_PAL_0:   sprite_palette_0 <= cfg_data;
        tssr_pkg::REG_SPR_PAL_1:   sprite_palette_1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      px    <= '0;
      spr_i <= '0;
      taken <= '0;
      nx    <= '0;
      grp   <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (cmd.operation == tssr_pkg::OP_RENDER) && !cmd.skip_line) begin
            line  <= cmd.line_number;
            px    <= '0;
            state <= S_BG_MAP;
          end
        end
        S_BG_MAP: state <= S_BG_NUM;
        S_BG_NUM: begin
          row_addr <= bg_row_addr;
          state    <= S_BG_LO;
        end
        S_BG_LO: begin
          lo_byte <= t_q;
          state   <= S_BG_HI;
        end
        S_BG_HI: begin
          px <= px + PXW'(1);
          if (px == PXW'(LINE_WIDTH - 1)) begin
            spr_i <= '0;
            taken <= '0;
            grp   <= '0;
            k     <= '0;
            pack  <= '0;
            state <= lcd_control[1] ? S_SC_Y : S_OUT_RD;
          end else begin
            state <= S_BG_MAP;
          end
        end
        S_SC_Y: state <= S_SC_X;
        S_SC_X: begin
          spr_y <= o_q;
          state <= S_SC_CHK;
        end
        S_SC_CHK: begin
          if (spr_hit) begin
            sel[TIW'(taken)] <= spr_i[SNW-1:0];
          end
          taken <= taken_inc;
          spr_i <= spr_i + SIW'(1);
          if ((spr_i == SIW'(SPRITE_COUNT - 1)) || (taken_inc == TKW'(MAX_SPRITES))) begin
            state <= (taken_inc != '0) ? S_SP_Y : S_OUT_RD;
          end else begin
            state <= S_SC_Y;
          end
        end
        S_SP_Y: state <= S_SP_X;
        S_SP_X: begin
          spr_y <= o_q;
          state <= S_SP_T;
        end
        S_SP_T: begin
          spr_x <= o_q;
          state <= S_SP_A;
        end
        S_SP_A: begin
          spr_tile <= o_q;
          state    <= S_SP_ADR;
        end
        S_SP_ADR: begin
          spr_attr <= o_q;
          row_addr <= spr_row_addr;
          state    <= S_SP_LO;
        end
        S_SP_LO: begin
          lo_byte <= t_q;
          state   <= S_SP_HI;
        end
        S_SP_HI: begin
          hi_byte <= t_q;
          nx      <= '0;
          state   <= S_SP_PRD;
        end
        S_SP_PRD: state <= S_SP_PWR;
        S_SP_PWR: begin
          nx <= nx + 3'd1;
          if (nx == 3'd7) begin
            // drawn from the highest taken index down so lower ones win
            taken <= taken - TKW'(1);
            state <= (taken == TKW'(1)) ? S_OUT_RD : S_SP_Y;
          end else begin
            state <= S_SP_PRD;
          end
        end
        S_OUT_RD: state <= S_OUT_CAP;
        S_OUT_CAP: begin
          pack[{k, 1'b0} +: 2] <= (9'(pos) < 9'(LINE_WIDTH)) ? s_q : 2'b00;
          k <= k + 3'd1;
          state <= (k == 3'd7) ? S_OUT_EMIT : S_OUT_RD;
        end
        S_OUT_EMIT: begin
          grp  <= grp + 5'd1;
          pack <= '0;
          state <= (grp == 5'(GROUPS - 1)) ? S_IDLE : S_OUT_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done               = (state == S_OUT_EMIT);
  assign result.pixel_group = grp;
  assign result.shades      = pack;
  assign result.last        = (grp == 5'(GROUPS - 1));

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a render");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (done && result.last) |=> !busy)
    else $error("render did not end after last group");
  a_render_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.operation == tssr_pkg::OP_RENDER) && !cmd.skip_line) |=> busy)
    else $error("render command not started");
  a_group_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.pixel_group < 5'(GROUPS)))
    else $error("group number out of range");

endmodule
